// File: hw/rtl/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants of the clipped line rasterizer
// Word layouts of both channels, the configuration register set, register
// indexes, opcodes and screen geometry.
// ----------------------------------------------------------------------------
package clr_pkg;

    // Screen and video memory geometry, in pixels.
    localparam int SCREEN_WIDTH  = 768;
    localparam int SCREEN_HEIGHT = 512;
    localparam int ROW_PIXELS    = 1024;
    localparam int MEMORY_ROWS   = 1024;

    localparam int          ADDR_W      = 24;
    localparam int          CFG_DATA_W  = 24;
    localparam int          CFG_INDEX_W = 3;
    localparam logic [3:0]  COLOR_MASK  = 4'hF;
    localparam logic [23:0] BASE_RESET  = 24'hC00000;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DRAWING_ENABLED = 3'd0,
        CFG_FRAME_BASE      = 3'd1,
        CFG_WIN_LEFT        = 3'd2,
        CFG_WIN_TOP         = 3'd3,
        CFG_CLIP_WIDTH      = 3'd4,
        CFG_CLIP_HEIGHT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         pen_color;
    } t_in_word;

    typedef struct packed {
        logic               write_enable;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [ADDR_W-1:0]  write_address;
        logic [3:0]         write_color;
        logic               last;
        logic               busy_res;
    } t_out_word;

    typedef struct packed {
        logic              drawing_enabled;
        logic [ADDR_W-1:0] frame_base;
        logic [9:0]        win_left;
        logic [8:0]        win_top;
        logic [9:0]        clip_width;
        logic [9:0]        clip_height;
    } t_cfg;

    // What the line walker reports for the word it is processing.
    typedef struct packed {
        logic        emit;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [3:0]  color;
        logic        last;
        logic        busy;
    } t_walk_pt;

    // Result of the clip and address check for one point.
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] address;
    } t_pix_res;

endpackage

// File: hw/rtl/clipped_line_rasterizer.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: clipped Bresenham line engine
// Walks a line one point per step word and produces a clipped pixel write.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Word
//   -------   ---------  -------------------------  ------------------------
//   in        to block   i_in_valid / o_in_stall    clr_pkg::t_in_word
//   out       from block o_out_valid / i_out_stall  clr_pkg::t_out_word
//   cfg       to block   i_cfg_wr_en (no wait)      index + 24-bit data
//
// Every input word gives exactly one output word. The block takes one word
// per cycle while the output is not stalled. An accepted word is held in the
// input register and moves into the result register when that register can
// take it; the result then stays valid on the output until it is taken.
// The line state updates in the same cycle the word leaves the input
// register, and that single Bresenham update sets the rate. Reset is
// synchronous and active low and clears the line state and the configuration
// to defaults. A stall on a full result register holds it and, if the
// input register is also full, raises o_in_stall in the same cycle.
//
module clipped_line_rasterizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  clr_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output clr_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_wr_en,
    input  logic [clr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    clr_pkg::t_cfg      cfg;
    clr_pkg::t_walk_pt  pt;
    clr_pkg::t_pix_res  pix;

    logic               r_in_vld;
    clr_pkg::t_in_word  r_in_word;
    logic               r_out_vld;
    clr_pkg::t_out_word r_out_word;
    clr_pkg::t_out_word n_out_word;

    logic out_free, fire, accept_in;

    // The result register can take a new word when it is empty or being
    // drained this cycle. The input register moves forward whenever the
    // result register can take its word.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept_in) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_word <= i_in_word;
        end
    end

    clr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    clr_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_word    (r_in_word),
        .i_draw_en (cfg.drawing_enabled),
        .o_pt      (pt)
    );

    clr_pixel u_pixel (
        .i_cfg (cfg),
        .i_pt  (pt),
        .o_res (pix)
    );

    // A start word and a step word on an idle engine both leave every point
    // field at zero; only busy_res reports the engine state.
    always_comb begin
        n_out_word.write_enable  = pix.write_enable;
        n_out_word.point_x       = pt.point_x;
        n_out_word.point_y       = pt.point_y;
        n_out_word.write_address = pix.address;
        n_out_word.write_color   = pt.color;
        n_out_word.last          = pt.last;
        n_out_word.busy_res      = pt.busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // The endpoint of a line always leaves the engine idle.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_word.last) |-> !r_out_word.busy_res)
        else $error("endpoint word reports the engine still busy");

    // A written pixel always lies on screen.
    a_write_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_word.write_enable) |->
            (!r_out_word.point_x[15] && !r_out_word.point_y[15]
             && (r_out_word.point_x < 16'(clr_pkg::SCREEN_WIDTH))
             && (r_out_word.point_y < 16'(clr_pkg::SCREEN_HEIGHT))))
        else $error("write enabled for an off-screen point");

    // A word entering a full input register must coincide with the held
    // word moving on, or it would be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && accept_in) |-> fire)
        else $error("input register overwritten while holding a word");

endmodule

// File: hw/rtl/clr_cfg.sv
// ----------------------------------------------------------------------------
// clr_cfg: configuration registers
// Holds the enable, frame base and clip rectangle, written by index.
// ----------------------------------------------------------------------------
module clr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [clr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output clr_pkg::t_cfg                       o_cfg
);

    clr_pkg::t_cfg r_cfg;
    clr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (clr_pkg::t_cfg_idx'(i_cfg_index))
                clr_pkg::CFG_DRAWING_ENABLED: n_cfg.drawing_enabled = i_cfg_wdata[0];
                clr_pkg::CFG_FRAME_BASE:      n_cfg.frame_base = i_cfg_wdata[23:0];
                clr_pkg::CFG_WIN_LEFT:        n_cfg.win_left = i_cfg_wdata[9:0];
                clr_pkg::CFG_WIN_TOP:         n_cfg.win_top = i_cfg_wdata[8:0];
                clr_pkg::CFG_CLIP_WIDTH:      n_cfg.clip_width = i_cfg_wdata[9:0];
                clr_pkg::CFG_CLIP_HEIGHT:     n_cfg.clip_height = i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drawing_enabled <= 1'b0;
            r_cfg.frame_base      <= clr_pkg::BASE_RESET;
            r_cfg.win_left        <= 10'd0;
            r_cfg.win_top         <= 9'd0;
            r_cfg.clip_width      <= 10'(clr_pkg::SCREEN_WIDTH);
            r_cfg.clip_height     <= 10'(clr_pkg::SCREEN_HEIGHT);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/clr_walker.sv
// ----------------------------------------------------------------------------
// clr_walker: Bresenham line state
// Loads a line on a start word and emits and advances one point per step word.
// ----------------------------------------------------------------------------
module clr_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  clr_pkg::t_in_word i_word,
    input  logic              i_draw_en,
    output clr_pkg::t_walk_pt o_pt
);

    logic [15:0] r_cursor_x, r_cursor_y, r_target_x, r_target_y;
    logic [15:0] r_delta_x, r_delta_y, r_error;
    logic        r_step_x_neg, r_step_y_neg, r_active;
    logic [3:0]  r_color;

    logic [15:0] n_cursor_x, n_cursor_y, n_target_x, n_target_y;
    logic [15:0] n_delta_x, n_delta_y, n_error;
    logic        n_step_x_neg, n_step_y_neg, n_active;
    logic [3:0]  n_color;

    logic               is_start, load, emit, at_end, c_x, c_y;
    logic [15:0]        dx, dy, adx, ady;
    logic signed [16:0] s_adx, s_ady, v, v_adj, e2, neg_dx, s_dy;

    // Start word: signed differences, magnitudes and the primed error term,
    // which is half of the x magnitude when larger, else minus half of the y
    // magnitude, rounded toward zero.
    always_comb begin
        is_start = (clr_pkg::t_opcode'(i_word.opcode) == clr_pkg::OP_START);
        dx       = i_word.end_x - i_word.start_x;
        dy       = i_word.end_y - i_word.start_y;
        adx      = dx[15] ? 16'(16'd0 - dx) : dx;
        ady      = dy[15] ? 16'(16'd0 - dy) : dy;
        s_adx    = {adx[15], adx};
        s_ady    = {ady[15], ady};
        v        = (s_adx > s_ady) ? s_adx : -s_ady;
        v_adj    = v + {16'd0, v[16]};
    end

    // Step word: one Bresenham update, both axes decided from the old error.
    always_comb begin
        emit   = !is_start && r_active;
        at_end = (r_cursor_x == r_target_x) && (r_cursor_y == r_target_y);
        e2     = {r_error[15], r_error};
        neg_dx = -{r_delta_x[15], r_delta_x};
        s_dy   = {r_delta_y[15], r_delta_y};
        c_x    = e2 > neg_dx;
        c_y    = e2 < s_dy;
        load   = is_start && i_draw_en;
    end

    always_comb begin
        n_cursor_x   = r_cursor_x;
        n_cursor_y   = r_cursor_y;
        n_target_x   = r_target_x;
        n_target_y   = r_target_y;
        n_delta_x    = r_delta_x;
        n_delta_y    = r_delta_y;
        n_error      = r_error;
        n_step_x_neg = r_step_x_neg;
        n_step_y_neg = r_step_y_neg;
        n_color      = r_color;
        n_active     = r_active;
        if (load) begin
            n_cursor_x   = i_word.start_x;
            n_cursor_y   = i_word.start_y;
            n_target_x   = i_word.end_x;
            n_target_y   = i_word.end_y;
            n_delta_x    = adx;
            n_delta_y    = ady;
            n_error      = v_adj[16:1];
            n_step_x_neg = dx[15];
            n_step_y_neg = dy[15];
            n_color      = i_word.pen_color[3:0] & clr_pkg::COLOR_MASK;
            n_active     = 1'b1;
        end else if (emit) begin
            if (at_end) begin
                n_active = 1'b0;
            end else begin
                n_error = 16'(r_error - (c_x ? r_delta_y : 16'd0)
                              + (c_y ? r_delta_x : 16'd0));
                if (c_x) begin
                    n_cursor_x = 16'(r_cursor_x + (r_step_x_neg ? 16'hFFFF : 16'd1));
                end
                if (c_y) begin
                    n_cursor_y = 16'(r_cursor_y + (r_step_y_neg ? 16'hFFFF : 16'd1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x   <= 16'd0;
            r_cursor_y   <= 16'd0;
            r_target_x   <= 16'd0;
            r_target_y   <= 16'd0;
            r_delta_x    <= 16'd0;
            r_delta_y    <= 16'd0;
            r_error      <= 16'd0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_color      <= 4'd0;
            r_active     <= 1'b0;
        end else if (i_fire) begin
            r_cursor_x   <= n_cursor_x;
            r_cursor_y   <= n_cursor_y;
            r_target_x   <= n_target_x;
            r_target_y   <= n_target_y;
            r_delta_x    <= n_delta_x;
            r_delta_y    <= n_delta_y;
            r_error      <= n_error;
            r_step_x_neg <= n_step_x_neg;
            r_step_y_neg <= n_step_y_neg;
            r_color      <= n_color;
            r_active     <= n_active;
        end
    end

    always_comb begin
        o_pt.emit    = emit;
        o_pt.point_x = emit ? r_cursor_x : 16'd0;
        o_pt.point_y = emit ? r_cursor_y : 16'd0;
        o_pt.color   = emit ? r_color : 4'd0;
        o_pt.last    = emit && at_end;
        o_pt.busy    = n_active;
    end

endmodule

// File: hw/rtl/clr_pixel.sv
// ----------------------------------------------------------------------------
// clr_pixel: clip test and pixel address
// Decides whether a point is written and forms its video memory byte address.
// ----------------------------------------------------------------------------
module clr_pixel (
    input  clr_pkg::t_cfg     i_cfg,
    input  clr_pkg::t_walk_pt i_pt,
    output clr_pkg::t_pix_res o_res
);

    localparam logic [31:0] MEM_PIXELS  = 32'(clr_pkg::ROW_PIXELS * clr_pkg::MEMORY_ROWS);
    localparam logic [23:0] LINE_STRIDE = 24'(clr_pkg::ROW_PIXELS * 2);

    logic        x_neg, y_neg, on_screen, in_clip, in_mem;
    logic [15:0] win_right, win_bottom;
    logic [31:0] lin;
    logic [23:0] x24, y24, addr;

    always_comb begin
        x_neg       = i_pt.point_x[15];
        y_neg       = i_pt.point_y[15];
        on_screen   = !x_neg && !y_neg
                      && (i_pt.point_x < 16'(clr_pkg::SCREEN_WIDTH))
                      && (i_pt.point_y < 16'(clr_pkg::SCREEN_HEIGHT));
        win_right   = 16'(i_cfg.win_left) + 16'(i_cfg.clip_width);
        win_bottom  = 16'(i_cfg.win_top) + 16'(i_cfg.clip_height);
        in_clip     = (i_pt.point_x >= 16'(i_cfg.win_left))
                      && (i_pt.point_x < win_right)
                      && (i_pt.point_y >= 16'(i_cfg.win_top))
                      && (i_pt.point_y < win_bottom);
        // Both coordinates are known non-negative whenever this is used.
        lin         = 32'(i_pt.point_y) * 32'(clr_pkg::ROW_PIXELS) + 32'(i_pt.point_x);
        in_mem      = lin < MEM_PIXELS;

        // The address wraps in 24 bits, so sign extension to 24 bits suffices.
        x24  = {{8{i_pt.point_x[15]}}, i_pt.point_x};
        y24  = {{8{i_pt.point_y[15]}}, i_pt.point_y};
        addr = 24'(i_cfg.frame_base + 24'(y24 * LINE_STRIDE) + {x24[22:0], 1'b0});

        o_res.write_enable = i_pt.emit && i_cfg.drawing_enabled
                             && on_screen && in_clip && in_mem;
        o_res.address      = i_pt.emit ? addr : 24'd0;
    end

endmodule

// File: tb/clipped_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_tb: self-checking bench for the clipped line engine
// Sends start and step words through the valid/stall input channel. A
// behavioral line walker in the bench predicts each pixel word, and the
// monitor compares every result field against that prediction. The clip
// window, frame base and drawing enable are changed between traffic phases,
// and both channels idle at random.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_tb;

    // A stretch this long with no word moving on either channel means the
    // block has hung.
    localparam int QUIET_LIMIT   = 2000;
    // Cycles allowed after the last result before the configuration changes.
    localparam int SETTLE_CYCLES = 4;
    // Length of the deliberate output hold-off that backs up the pipeline.
    localparam int HOLD_CYCLES   = 60;
    // Only the first mismatches are printed, to keep the log short.
    localparam int PRINT_LIMIT   = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    clr_pkg::t_in_word               in_word = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    clr_pkg::t_out_word              out_word;
    logic                            cfg_wr_en = 1'b0;
    logic [clr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [clr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    clipped_line_rasterizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line walker used for prediction. It keeps its own copy of the line state
    // and of the register settings; the settings copy is updated by the
    // register write task, which runs only while no word is in flight.
    // ------------------------------------------------------------------------
    clr_pkg::t_cfg view_cfg;
    logic [15:0]   pen_x, pen_y, goal_x, goal_y;
    logic [15:0]   span_x, span_y, err_term;
    logic          back_x, back_y;
    logic [3:0]    line_color;
    logic          walking;

    clr_pkg::t_in_word  pending_words[$];
    clr_pkg::t_out_word expected_pixels[$];

    int  words_sent = 0;
    int  results_checked = 0;
    int  pixels_written = 0;
    int  lines_finished = 0;
    int  mismatches = 0;
    int  words_queued = 0;
    bit  idling_on = 1'b1;
    int  hold_request = 0;
    bit  in_taken = 1'b0;

    // Works out the pixel word for one accepted input word and advances the
    // line state the way the block must.
    function automatic clr_pkg::t_out_word rasterize_word(clr_pkg::t_in_word w);
        clr_pkg::t_out_word r;
        logic [15:0]        dx, dy;
        logic [31:0]        addr;
        int                 adx, ady, half, px, py, e2;
        int                 cl, ct, cw, ch;
        bit                 ok;
        r = '0;
        if (w.opcode == clr_pkg::OP_START) begin
            // A start while drawing is disabled leaves everything alone.
            if (view_cfg.drawing_enabled) begin
                dx = w.end_x - w.start_x;
                dy = w.end_y - w.start_y;
                back_x = dx[15];
                back_y = dy[15];
                span_x = dx[15] ? 16'd0 - dx : dx;
                span_y = dy[15] ? 16'd0 - dy : dy;
                // Magnitudes are read back as signed, so a difference of
                // exactly 0x8000 stays negative here.
                adx = $signed(span_x);
                ady = $signed(span_y);
                half = (adx > ady) ? adx : -ady;
                err_term = 16'(half / 2);
                pen_x = w.start_x;
                pen_y = w.start_y;
                goal_x = w.end_x;
                goal_y = w.end_y;
                line_color = w.pen_color[3:0] & clr_pkg::COLOR_MASK;
                walking = 1'b1;
            end
        end else if (walking) begin
            px = $signed(pen_x);
            py = $signed(pen_y);
            cl = view_cfg.win_left;
            ct = view_cfg.win_top;
            cw = view_cfg.clip_width;
            ch = view_cfg.clip_height;
            ok = view_cfg.drawing_enabled
                && px >= 0 && px < clr_pkg::SCREEN_WIDTH
                && py >= 0 && py < clr_pkg::SCREEN_HEIGHT
                && px >= cl && px < cl + cw && py >= ct && py < ct + ch;
            ok = ok && (py * clr_pkg::ROW_PIXELS * 2 + px * 2
                        < clr_pkg::ROW_PIXELS * clr_pkg::MEMORY_ROWS * 2);
            // The address is formed even off screen and simply wraps.
            addr = view_cfg.frame_base + py * (clr_pkg::ROW_PIXELS * 2) + px * 2;
            r.write_enable = ok;
            r.point_x = pen_x;
            r.point_y = pen_y;
            r.write_address = addr[clr_pkg::ADDR_W-1:0];
            r.write_color = line_color;
            if (pen_x == goal_x && pen_y == goal_y) begin
                r.last = 1'b1;
                walking = 1'b0;
            end else begin
                e2 = $signed(err_term);
                adx = $signed(span_x);
                ady = $signed(span_y);
                if (e2 > -adx) begin
                    err_term = err_term - span_y;
                    pen_x = pen_x + (back_x ? 16'hFFFF : 16'h0001);
                end
                if (e2 < ady) begin
                    err_term = err_term + span_x;
                    pen_y = pen_y + (back_y ? 16'hFFFF : 16'h0001);
                end
            end
        end
        r.busy_res = walking;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. It changes the channel on the falling edge only. Once a
    // word is offered it stays put until the block takes it; valid never
    // looks at the stall. Between words it may pause for a random burst.
    // ------------------------------------------------------------------------
    int gap_left = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            in_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            in_valid <= 1'b0;
        end else if (idling_on && pending_words.size() > 0 && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 13) - 1;
            in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            in_word <= pending_words.pop_front();
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Output side stall. A hold request from the main sequence wins over the
    // random bursts and is counted down here, cycle by cycle.
    int stall_left = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_request > 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (mismatches < PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge it records an accepted input word together
    // with its predicted result, and checks any result word leaving the
    // block against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        clr_pkg::t_out_word want;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken) begin
            expected_pixels.push_back(rasterize_word(in_word));
            words_sent++;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                if (mismatches < PRINT_LIMIT)
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, out_word);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("write_enable", 32'(want.write_enable),
                            32'(out_word.write_enable));
                check_field("point_x", 32'(want.point_x), 32'(out_word.point_x));
                check_field("point_y", 32'(want.point_y), 32'(out_word.point_y));
                check_field("write_address", 32'(want.write_address),
                            32'(out_word.write_address));
                check_field("write_color", 32'(want.write_color), 32'(out_word.write_color));
                check_field("last", 32'(want.last), 32'(out_word.last));
                check_field("busy_res", 32'(want.busy_res), 32'(out_word.busy_res));
                results_checked++;
                if (want.write_enable)
                    pixels_written++;
                if (want.last)
                    lines_finished++;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles at %0t", quiet_cycles, $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic clr_pkg::t_in_word random_word();
        clr_pkg::t_in_word w;
        logic [95:0]       raw;
        raw = {$urandom(), $urandom(), $urandom()};
        w = raw[$bits(clr_pkg::t_in_word)-1:0];
        return w;
    endfunction

    task automatic queue_start(int x1, int y1, int x2, int y2, int color);
        clr_pkg::t_in_word w;
        w = random_word();
        w.opcode = clr_pkg::OP_START;
        w.start_x = 16'(x1);
        w.start_y = 16'(y1);
        w.end_x = 16'(x2);
        w.end_y = 16'(y2);
        w.pen_color = 8'(color);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Step words carry random payload, which the block must ignore.
    task automatic queue_steps(int count);
        clr_pkg::t_in_word w;
        repeat (count) begin
            w = random_word();
            w.opcode = clr_pkg::OP_STEP;
            pending_words.push_back(w);
            words_queued++;
        end
    endtask

    // One piece of random traffic. Most pieces are complete short lines near
    // the screen or the clip window; the rest are lines cut short, lines with
    // endpoints anywhere in the 16-bit range, and raw noise words.
    task automatic queue_random_piece();
        int kind, x1, y1, x2, y2, len, adx, ady;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 2) == 0) begin
                // Start around a corner of the clip window.
                x1 = int'(view_cfg.win_left)
                     + ($urandom_range(0, 1) ? int'(view_cfg.clip_width) : 0)
                     + $urandom_range(0, 10) - 5;
                y1 = int'(view_cfg.win_top)
                     + ($urandom_range(0, 1) ? int'(view_cfg.clip_height) : 0)
                     + $urandom_range(0, 10) - 5;
            end else begin
                x1 = $urandom_range(0, 830) - 40;
                y1 = $urandom_range(0, 580) - 40;
            end
            x2 = x1 + $urandom_range(0, 60) - 30;
            y2 = y1 + $urandom_range(0, 60) - 30;
            adx = (x2 > x1) ? x2 - x1 : x1 - x2;
            ady = (y2 > y1) ? y2 - y1 : y1 - y2;
            len = ((adx > ady) ? adx : ady) + 1;
            queue_start(x1, y1, x2, y2, $urandom_range(0, 255));
            if (kind < 70)
                queue_steps(len + ($urandom_range(0, 3) == 0 ? 1 : 0));
            else
                queue_steps($urandom_range(0, len - 1));
        end else if (kind < 88) begin
            queue_start($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 255));
            queue_steps($urandom_range(1, 6));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                pending_words.push_back(random_word());
                words_queued++;
            end
        end
    endtask

    task automatic queue_random_traffic(int count);
        int target;
        target = words_queued + count;
        while (words_queued < target)
            queue_random_piece();
    endtask

    // Waits until every queued word has gone in and every result has come
    // out, then lets the pipeline settle before anything is reconfigured.
    task automatic wait_until_drained();
        @(posedge clk);
        while (pending_words.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(clr_pkg::t_cfg_idx idx, int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= clr_pkg::CFG_DATA_W'(value);
        case (idx)
            clr_pkg::CFG_DRAWING_ENABLED: view_cfg.drawing_enabled = value[0];
            clr_pkg::CFG_FRAME_BASE:      view_cfg.frame_base = value[clr_pkg::ADDR_W-1:0];
            clr_pkg::CFG_WIN_LEFT:        view_cfg.win_left = value[9:0];
            clr_pkg::CFG_WIN_TOP:         view_cfg.win_top = value[8:0];
            clr_pkg::CFG_CLIP_WIDTH:      view_cfg.clip_width = value[9:0];
            clr_pkg::CFG_CLIP_HEIGHT:     view_cfg.clip_height = value[9:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(int enable, int base, int left, int top, int width,
                                  int height);
        write_register(clr_pkg::CFG_DRAWING_ENABLED, enable);
        write_register(clr_pkg::CFG_FRAME_BASE, base);
        write_register(clr_pkg::CFG_WIN_LEFT, left);
        write_register(clr_pkg::CFG_WIN_TOP, top);
        write_register(clr_pkg::CFG_CLIP_WIDTH, width);
        write_register(clr_pkg::CFG_CLIP_HEIGHT, height);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        view_cfg = '{drawing_enabled: 1'b0, frame_base: clr_pkg::BASE_RESET, win_left: '0,
                     win_top: '0, clip_width: 10'(clr_pkg::SCREEN_WIDTH),
                     clip_height: 10'(clr_pkg::SCREEN_HEIGHT)};
        pen_x = '0; pen_y = '0; goal_x = '0; goal_y = '0;
        span_x = '0; span_y = '0; err_term = '0;
        back_x = 1'b0; back_y = 1'b0; line_color = '0; walking = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Out of reset drawing is off: a step with no line gives an all-zero
        // word, and a start is ignored, so the following step is zero too.
        queue_steps(1);
        queue_start(10, 10, 20, 12, 8'h5A);
        queue_steps(1);
        wait_until_drained();

        apply_settings(1, clr_pkg::BASE_RESET, 0, 0, clr_pkg::SCREEN_WIDTH,
                       clr_pkg::SCREEN_HEIGHT);

        // Short line with the upper pen bits set, plus one step past its end.
        queue_start(0, 0, 3, 1, 8'hF5);
        queue_steps(5);
        // Line that starts on the last pixel of the screen and leaves it.
        queue_start(clr_pkg::SCREEN_WIDTH - 1, clr_pkg::SCREEN_HEIGHT - 1,
                    clr_pkg::SCREEN_WIDTH + 1, clr_pkg::SCREEN_HEIGHT + 1, 8'h0A);
        queue_steps(3);
        // Endpoints at the extremes of the 16-bit range; the difference wraps.
        queue_start(-32768, 32767, 32767, -32768, 8'hFF);
        queue_steps(2);
        // A new start while that line is still active replaces it, and a line
        // of a single point is finished on its first step.
        queue_start(5, 5, 5, 5, 8'h00);
        queue_steps(1);
        // A difference of exactly 0x8000, whose magnitude stays negative.
        queue_start(0, 0, -32768, 0, 8'h80);
        queue_steps(2);
        // First point above and left of the screen gives a wrapped address.
        queue_start(-1, -1, 1, 1, 8'h03);
        queue_steps(3);
        wait_until_drained();

        // Full clip window, with a long output hold-off partway through.
        queue_random_traffic(120);
        hold_request = HOLD_CYCLES;
        queue_random_traffic(100);
        wait_until_drained();

        // Highest frame base and clip origin at its largest on-screen values.
        apply_settings(1, 24'hFFFFFF, clr_pkg::SCREEN_WIDTH - 1, clr_pkg::SCREEN_HEIGHT - 1,
                       clr_pkg::SCREEN_WIDTH, clr_pkg::SCREEN_HEIGHT);
        queue_random_traffic(200);
        wait_until_drained();

        // Empty clip window and a zero frame base, run without any idling.
        idling_on = 1'b0;
        apply_settings(1, 0, 0, 0, 0, 0);
        queue_random_traffic(150);
        wait_until_drained();
        idling_on = 1'b1;

        // Random clip window and frame base.
        apply_settings(1, $urandom_range(0, 24'hFFFFFF),
                       $urandom_range(0, clr_pkg::SCREEN_WIDTH - 1),
                       $urandom_range(0, clr_pkg::SCREEN_HEIGHT - 1),
                       $urandom_range(0, clr_pkg::SCREEN_WIDTH),
                       $urandom_range(0, clr_pkg::SCREEN_HEIGHT));
        queue_random_traffic(200);
        wait_until_drained();

        // Leave a line half drawn, then turn drawing off: its remaining steps
        // still walk with no writes, and new starts are ignored.
        apply_settings(1, clr_pkg::BASE_RESET, 0, 0, clr_pkg::SCREEN_WIDTH,
                       clr_pkg::SCREEN_HEIGHT);
        queue_start(100, 100, 140, 120, 8'h07);
        queue_steps(3);
        wait_until_drained();
        apply_settings(0, $urandom_range(0, 24'hFFFFFF), 0, 0, clr_pkg::SCREEN_WIDTH,
                       clr_pkg::SCREEN_HEIGHT);
        queue_random_traffic(150);
        wait_until_drained();

        // Final stretch: an ordinary inner window and no idling on either side.
        idling_on = 1'b0;
        apply_settings(1, clr_pkg::BASE_RESET, 100, 50, 300, 200);
        queue_random_traffic(200);
        wait_until_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d input words and %0d checked results over seven settings.",
                 words_sent, results_checked);
        $display("Pixel writes seen: %0d, lines finished: %0d, mismatches: %0d.",
                 pixels_written, lines_finished, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
